// ----- sv/swtm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window throughput meter package
// Shared types and constants for the throughput meter and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package swtm_pkg;

   localparam int unsigned DEFAULT_FIFO_DEPTH = 1024;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned BYTES_W = 16;
   localparam int unsigned CFG_W = 16;
   localparam int unsigned BPS_W = 36;
   localparam int unsigned BITS_W = 39;
   localparam int unsigned PPS_W = 20;
   localparam int unsigned SCALE_W = 10;
   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   localparam logic [SCALE_W-1:0] MS_PER_SECOND = SCALE_W'(1000);
   localparam logic [CFG_W-1:0] RESET_INTERVAL = CFG_W'(1000);
   localparam logic [CFG_W-1:0] RESET_WINDOW = CFG_W'(1000);

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic REG_INTERVAL = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   typedef struct packed {
      logic op;
      logic [BYTES_W-1:0] packet_bytes;
   } req_type;

   typedef struct packed {
      logic [BPS_W-1:0] byte_rate;
      logic [BITS_W-1:0] bit_rate;
      logic [PPS_W-1:0] packet_rate;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [BYTES_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic valid;
      req_type item;
   } work_type;

endpackage

`default_nettype wire

// ----- sv/swtm_front.sv -----
// ----------------------------------------------------------------------------
// Throughput meter front end
// Accepts request beats into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swtm_front
   import swtm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire req_type req_data,
   output work_type work,
   input wire logic work_ready
);

   req_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign work.valid = (count_ff != 2'd0);
   assign work.item = slot_ff[rd_ptr_ff];
   assign do_pop = work.valid && work_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/swtm_back.sv -----
// ----------------------------------------------------------------------------
// Throughput meter back end
// Logs packets, keeps time, evicts old entries and divides out the report.
// ----------------------------------------------------------------------------
`default_nettype none

module swtm_back
   import swtm_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
)
(
   input wire logic clock,
   input wire logic reset,
   input wire work_type work,
   output logic work_ready,
   input wire logic [CFG_W-1:0] interval_ms,
   input wire logic [CFG_W-1:0] window_ms,
   output logic empty,
   input wire logic pop,
   output rsp_type rsp_data
);

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned SUM_W = PTR_W + BYTES_W;
   localparam int unsigned DIV_W = (SUM_W + SCALE_W > BPS_W) ? SUM_W + SCALE_W : BPS_W;
   localparam int unsigned STEP_W = $clog2(DIV_W + 1);
   localparam int unsigned REM_W = CFG_W + 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EVRD = 6'b000010,
      S_EVCHK = 6'b000100,
      S_MUL = 6'b001000,
      S_DIV = 6'b010000,
      S_OUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   entry_type mem [FIFO_DEPTH];
   entry_type rd_ff;
   logic wr_en;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [CFG_W-1:0] icnt_ff, icnt_in, icnt_next;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic ovf_ff, ovf_in;
   logic [DIV_W-1:0] bq_ff, bq_in, pq_ff, pq_in;
   logic [REM_W-1:0] brem_ff, brem_in, prem_ff, prem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [CFG_W-1:0] ivl, win;
   logic [TIME_W-1:0] age;
   logic [REM_W-1:0] bsh, psh;
   logic fifo_full;

   assign ivl = (interval_ms == '0) ? CFG_W'(1) : interval_ms;
   assign win = (window_ms == '0) ? CFG_W'(1) : window_ms;
   assign age = now_ff - rd_ff.stamp;
   assign fifo_full = (count_ff == CNT_W'(FIFO_DEPTH));
   assign icnt_next = icnt_ff + CFG_W'(1);
   assign bsh = {brem_ff[REM_W-2:0], bq_ff[DIV_W-1]};
   assign psh = {prem_ff[REM_W-2:0], pq_ff[DIV_W-1]};

   assign work_ready = (state_ff == S_IDLE);
   assign empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
      return (i == PTR_W'(FIFO_DEPTH - 1)) ? '0 : i + PTR_W'(1);
   endfunction

   always_comb begin
      state_in = state_ff;
      now_in = now_ff;
      icnt_in = icnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      bq_in = bq_ff;
      pq_in = pq_ff;
      brem_in = brem_ff;
      prem_in = prem_ff;
      step_in = step_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      wr_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (work.valid) begin
               if (work.item.op == OP_TICK) begin
                  now_in = now_ff + TIME_W'(1);
                  if (icnt_next >= ivl) begin
                     icnt_in = '0;
                     state_in = S_EVRD;
                  end else begin
                     icnt_in = icnt_next;
                  end
               end else if (fifo_full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  tail_in = next_slot(tail_ff);
                  count_in = count_ff + CNT_W'(1);
                  sum_in = sum_ff + SUM_W'(work.item.packet_bytes);
               end
            end
         end
         S_EVRD: begin
            state_in = S_EVCHK;
         end
         S_EVCHK: begin
            if (count_ff != '0 && age >= TIME_W'(win)) begin
               head_in = next_slot(head_ff);
               count_in = count_ff - CNT_W'(1);
               sum_in = sum_ff - SUM_W'(rd_ff.size);
               state_in = S_EVRD;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            bq_in = DIV_W'(sum_ff) * DIV_W'(MS_PER_SECOND);
            pq_in = DIV_W'(count_ff) * DIV_W'(MS_PER_SECOND);
            brem_in = '0;
            prem_in = '0;
            step_in = STEP_W'(DIV_W);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (bsh >= REM_W'(win)) begin
               brem_in = bsh - REM_W'(win);
               bq_in = {bq_ff[DIV_W-2:0], 1'b1};
            end else begin
               brem_in = bsh;
               bq_in = {bq_ff[DIV_W-2:0], 1'b0};
            end
            if (psh >= REM_W'(win)) begin
               prem_in = psh - REM_W'(win);
               pq_in = {pq_ff[DIV_W-2:0], 1'b1};
            end else begin
               prem_in = psh;
               pq_in = {pq_ff[DIV_W-2:0], 1'b0};
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_in.byte_rate = bq_ff[BPS_W-1:0];
               rsp_in.bit_rate = {bq_ff[BPS_W-1:0], 3'b000};
               rsp_in.packet_rate = pq_ff[PPS_W-1:0];
               rsp_in.overflow = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         now_ff <= '0;
         icnt_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff <= now_in;
         icnt_ff <= icnt_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bq_ff <= bq_in;
      pq_ff <= pq_in;
      brem_ff <= brem_in;
      prem_ff <= prem_in;
      step_ff <= step_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= '{stamp: now_ff, size: work.item.packet_bytes};
      end
      rd_ff <= mem[head_ff];
   end

endmodule

`default_nettype wire

// ----- sv/sliding_window_throughput_meter.sv -----
// ----------------------------------------------------------------------------
// Sliding window throughput meter
// Reports byte, bit and packet rates over a sliding millisecond window.
// ----------------------------------------------------------------------------
// Request beats enter through push and full. A packet beat logs its byte count
// with the current time; a tick beat advances time by one millisecond.
// Every interval_ms ticks the block evicts entries at least window_ms old and
// queues one report, read through empty and pop.
// A beat is registered in the front queue and the back end takes a packet or
// plain tick when idle, so beats are accepted one per cycle while it stays idle.
// A reporting tick keeps the back end busy: after the tick it reads and checks
// the oldest entry through the registered read of the entry memory, again for
// each evicted entry, then does a multiply step and runs two bit-serial
// dividers side by side before the output state registers its report.
// The front queue holds two beats, so requests keep flowing while the back end
// is busy until the queue fills.
// If the receiver stalls, the report waits in the output register and the next
// report holds the back end until it is taken. Packets that find the log full
// are dropped and set the sticky overflow flag.
// Reset clears time, counters, the log and the flag, and sets both registers to
// 1000; no clearing pass over the memory is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_throughput_meter
   import swtm_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
)
(
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire req_type req_data,
   output logic empty,
   input wire logic pop,
   output rsp_type rsp_data,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [ADDR_W-1:0] paddr,
   input wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic pready
);

   logic [CFG_W-1:0] interval_ff, interval_in;
   logic [CFG_W-1:0] window_ff, window_in;
   logic csr_wr;
   work_type work;
   logic work_ready;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      interval_in = interval_ff;
      window_in = window_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_INTERVAL: interval_in = pwdata[CFG_W-1:0];
            REG_WINDOW: window_in = pwdata[CFG_W-1:0];
            default: begin
               interval_in = interval_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_INTERVAL: prdata = DATA_W'(interval_ff);
         REG_WINDOW: prdata = DATA_W'(window_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= RESET_INTERVAL;
         window_ff <= RESET_WINDOW;
      end else begin
         interval_ff <= interval_in;
         window_ff <= window_in;
      end
   end

   swtm_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .work(work),
      .work_ready(work_ready)
   );

   swtm_back #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .work(work),
      .work_ready(work_ready),
      .interval_ms(interval_ff),
      .window_ms(window_ff),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire
